FILE: src/tclf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclf_pkg
// Shared types and constants of the two-class line fit unit.
// ----------------------------------------------------------------------------
package tclf_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = COORD_BITS + CNT_W;
  localparam int SQ_W   = 2 * COORD_BITS + CNT_W;
  localparam int NUM_W  = SUM_W + SQ_W + 16;
  localparam int R_W    = ((COORD_BITS + 31 > 47) ? COORD_BITS + 31 : 47) + 2;
  localparam int VW     = 2 * R_W + 64;
  localparam int SVW    = VW + 1;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  typedef logic signed [COORD_BITS-1:0]   coord_t;
  typedef logic signed [2*COORD_BITS-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]        sum_t;
  typedef logic signed [SQ_W-1:0]         sq_t;
  typedef logic signed [SVW-1:0]          svw_t;
  typedef logic [VW-1:0]                  mag_t;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_FIT      = 2'd1,
    OP_CLASSIFY = 2'd2,
    OP_CLEAR    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DROP  = 2'd1,
    STAT_NOFIT = 2'd2
  } status_t;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_cmd_t;

  typedef enum logic [1:0] {
    AST_IDLE,
    AST_MUL,
    AST_DIV
  } alu_state_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_ACC,
    SEQ_ISSUE,
    SEQ_WAIT,
    SEQ_OUT
  } seq_state_t;

  typedef enum logic [3:0] {
    STEP_DEN0,
    STEP_DEN1,
    STEP_SN0,
    STEP_SN1,
    STEP_SDIV,
    STEP_ON0,
    STEP_ON1,
    STEP_ODIV,
    STEP_MX,
    STEP_RR,
    STEP_MM,
    STEP_A,
    STEP_B
  } step_t;

endpackage

FILE: src/tclf_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclf_alu
// Shared shift-add multiplier and restoring divider on unsigned magnitudes.
// ----------------------------------------------------------------------------
module tclf_alu
  import tclf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  alu_cmd_t cmd,
  input  mag_t     opa,
  input  mag_t     opb,
  output logic     done,
  output mag_t     res
);

  alu_state_t state, state_next;
  mag_t acc, ma, mb;
  logic [NUM_W-1:0] num;
  logic [DCNT_W-1:0] cnt;
  mag_t trial;
  logic take;

  assign trial = {ma[VW-2:0], num[NUM_W-1]};
  assign take  = (trial >= mb);
  assign res   = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    unique case (state)
      AST_IDLE: begin
        if (cmd.start) begin
          state_next = (cmd.op == ALU_DIV) ? AST_DIV : AST_MUL;
        end
      end
      AST_MUL: begin
        if (mb == '0) begin
          done       = 1'b1;
          state_next = AST_IDLE;
        end
      end
      AST_DIV: begin
        if (cnt == '0) begin
          done       = 1'b1;
          state_next = AST_IDLE;
        end
      end
      default: state_next = AST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      AST_IDLE: begin
        if (cmd.start) begin
          acc <= '0;
          if (cmd.op == ALU_DIV) begin
            ma  <= '0;
            mb  <= opb;
            num <= opa[NUM_W-1:0];
            cnt <= DCNT_W'(NUM_W);
          end else begin
            ma <= opa;
            mb <= opb;
          end
        end
      end
      AST_MUL: begin
        // add the shifted multiplicand for each set multiplier bit
        if (mb != '0) begin
          if (mb[0]) acc <= acc + ma;
          ma <= {ma[VW-2:0], 1'b0};
          mb <= {1'b0, mb[VW-1:1]};
        end
      end
      AST_DIV: begin
        if (cnt != '0) begin
          ma  <= take ? trial - mb : trial;
          acc <= {acc[VW-2:0], take};
          num <= {num[NUM_W-2:0], 1'b0};
          cnt <= cnt - 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: src/two_class_least_squares_line_fit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_least_squares_line_fit_unit
// Two-class least-squares line fit with nearest-line classification.
// ----------------------------------------------------------------------------
// Each transaction carries an opcode: add a labelled Q8.8 training point,
// fit both class lines to signed Q16.16 (truncated, saturated), classify a
// point by exact squared perpendicular distance, or clear the sums. Every
// transaction returns one result holding both stored lines, their fit flags,
// the predicted class and a status. One item is worked at a time and input
// is stalled until its result has been taken. Clear and a dropped add go
// straight to the result; an accepted add first updates the sums. Fit and
// classify run on a single shared shift-add multiplier / restoring divider:
// the multiplier runs until its shifted multiplier is zero, and the divider
// works through every bit of the numerator.
// ----------------------------------------------------------------------------
module two_class_least_squares_line_fit_unit
  import tclf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic signed [15:0] x_coord,
  input  logic signed [15:0] y_coord,
  input  logic               point_class,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] slope_zero,
  output logic signed [31:0] offset_zero,
  output logic signed [31:0] slope_one,
  output logic signed [31:0] offset_one,
  output logic               fit_ok_zero,
  output logic               fit_ok_one,
  output logic               predicted_class,
  output logic [1:0]         status
);

  // Model state
  logic [CNT_W-1:0]   class_count [2];
  sum_t               sum_x       [2];
  sum_t               sum_y       [2];
  sq_t                sum_xy      [2];
  sq_t                sum_xx      [2];
  logic signed [31:0] line_slope  [2];
  logic signed [31:0] line_offset [2];
  logic [1:0]         line_valid;
  logic               fit_done;

  // Item and sequencer registers
  seq_state_t state, state_next;
  step_t      step;
  logic       cls;
  coord_t     x_reg, y_reg;
  logic       lbl;
  prod_t      pxy, pxx;
  svw_t       t0, den, numr, rtmp;
  mag_t       rr [2];
  mag_t       dd [2];
  logic       pred;
  status_t    stat;

  // Shared unit interface
  alu_cmd_t cmd;
  mag_t     opa, opb;
  logic     alu_done;
  mag_t     alu_res;

  logic    accept;
  opcode_t op_in;
  coord_t  x_in, y_in;
  svw_t    sa, sb, prod, den_v, num_v;
  alu_op_t aop;
  logic [4:0] shamt;
  mag_t    mag_a, mag_b;
  logic    neg;
  logic    den_bad;

  function automatic logic signed [31:0] sat_q(input logic ng, input mag_t q);
    logic signed [31:0] r;
    if (q == '0) begin
      r = '0;
    end else if (ng) begin
      r = (q > VW'(33'h0_8000_0000)) ? 32'sh8000_0000 : -$signed(q[31:0]);
    end else begin
      r = (q > VW'(33'h0_7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    end
    return r;
  endfunction

  assign op_in  = opcode_t'(opcode);
  assign x_in   = x_coord[COORD_BITS-1:0];
  assign y_in   = y_coord[COORD_BITS-1:0];
  assign accept = in_valid && !in_stall;

  assign in_stall        = (state != SEQ_IDLE);
  assign out_valid       = (state == SEQ_OUT);
  assign slope_zero      = line_slope[0];
  assign offset_zero     = line_offset[0];
  assign slope_one       = line_slope[1];
  assign offset_one      = line_offset[1];
  assign fit_ok_zero     = line_valid[0];
  assign fit_ok_one      = line_valid[1];
  assign predicted_class = pred;
  assign status          = stat;

  // Operand selection for the current step
  always_comb begin
    sa    = '0;
    sb    = '0;
    aop   = ALU_MUL;
    shamt = '0;
    unique case (step)
      STEP_DEN0: begin
        sa = svw_t'(signed'({1'b0, class_count[cls]}));
        sb = svw_t'(sum_xx[cls]);
      end
      STEP_DEN1: begin
        sa = svw_t'(sum_x[cls]);
        sb = svw_t'(sum_x[cls]);
      end
      STEP_SN0: begin
        sa = svw_t'(signed'({1'b0, class_count[cls]}));
        sb = svw_t'(sum_xy[cls]);
      end
      STEP_SN1: begin
        sa = svw_t'(sum_x[cls]);
        sb = svw_t'(sum_y[cls]);
      end
      STEP_SDIV: begin
        aop   = ALU_DIV;
        sa    = numr;
        sb    = den;
        shamt = 5'd16;
      end
      STEP_ON0: begin
        sa = svw_t'(sum_y[cls]);
        sb = svw_t'(sum_xx[cls]);
      end
      STEP_ON1: begin
        sa = svw_t'(sum_xy[cls]);
        sb = svw_t'(sum_x[cls]);
      end
      STEP_ODIV: begin
        aop   = ALU_DIV;
        sa    = numr;
        sb    = den;
        shamt = 5'(16 - FRAC_BITS);
      end
      STEP_MX: begin
        sa = svw_t'(line_slope[cls]);
        sb = svw_t'(x_reg);
      end
      STEP_RR: begin
        sa = rtmp;
        sb = rtmp;
      end
      STEP_MM: begin
        sa = svw_t'(line_slope[cls]);
        sb = svw_t'(line_slope[cls]);
      end
      STEP_A: begin
        sa = svw_t'({1'b0, rr[0]});
        sb = svw_t'({1'b0, dd[1]});
      end
      STEP_B: begin
        sa = svw_t'({1'b0, rr[1]});
        sb = svw_t'({1'b0, dd[0]});
      end
      default: ;
    endcase
  end

  assign mag_a = sa[SVW-1] ? VW'(-sa) : VW'(sa);
  assign mag_b = sb[SVW-1] ? VW'(-sb) : VW'(sb);
  assign neg   = sa[SVW-1] ^ sb[SVW-1];
  assign opa   = (aop == ALU_DIV) ? (mag_a << shamt) : mag_a;
  assign opb   = mag_b;
  assign cmd   = '{start: (state == SEQ_ISSUE), op: aop};

  // Signed product and the differences formed from it
  assign prod    = neg ? -svw_t'({1'b0, alu_res}) : svw_t'({1'b0, alu_res});
  assign den_v   = t0 - prod;
  assign den_bad = den_v[SVW-1] || (den_v == '0);
  assign num_v   = prod - (svw_t'(y_reg) <<< 16) + (svw_t'(line_offset[cls]) <<< FRAC_BITS);

  tclf_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .opa  (opa),
    .opb  (opb),
    .done (alu_done),
    .res  (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: begin
        if (accept) begin
          unique case (op_in)
            OP_ADD: begin
              state_next = (class_count[point_class] >= CNT_W'(MAX_POINTS)) ? SEQ_OUT : SEQ_ACC;
            end
            OP_FIT:   state_next = SEQ_ISSUE;
            OP_CLEAR: state_next = SEQ_OUT;
            OP_CLASSIFY: begin
              state_next = (fit_done && (&line_valid)) ? SEQ_ISSUE : SEQ_OUT;
            end
            default: state_next = SEQ_OUT;
          endcase
        end
      end
      SEQ_ACC:   state_next = SEQ_OUT;
      SEQ_ISSUE: state_next = SEQ_WAIT;
      SEQ_WAIT: begin
        if (alu_done) begin
          if (step == STEP_B) begin
            state_next = SEQ_OUT;
          end else if (((step == STEP_DEN1) && den_bad) || (step == STEP_ODIV)) begin
            state_next = cls ? SEQ_OUT : SEQ_ISSUE;
          end else begin
            state_next = SEQ_ISSUE;
          end
        end
      end
      SEQ_OUT: begin
        if (!out_stall) state_next = SEQ_IDLE;
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  // Model state: reset and updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        class_count[i] <= '0;
        sum_x[i]       <= '0;
        sum_y[i]       <= '0;
        sum_xy[i]      <= '0;
        sum_xx[i]      <= '0;
        line_slope[i]  <= '0;
        line_offset[i] <= '0;
      end
      line_valid <= '0;
      fit_done   <= 1'b0;
    end else begin
      if (accept && (op_in == OP_CLEAR)) begin
        for (int i = 0; i < 2; i++) begin
          class_count[i] <= '0;
          sum_x[i]       <= '0;
          sum_y[i]       <= '0;
          sum_xy[i]      <= '0;
          sum_xx[i]      <= '0;
        end
      end
      if (state == SEQ_ACC) begin
        class_count[lbl] <= class_count[lbl] + 1'b1;
        sum_x[lbl]       <= sum_x[lbl] + sum_t'(x_reg);
        sum_y[lbl]       <= sum_y[lbl] + sum_t'(y_reg);
        sum_xy[lbl]      <= sum_xy[lbl] + sq_t'(pxy);
        sum_xx[lbl]      <= sum_xx[lbl] + sq_t'(pxx);
      end
      if ((state == SEQ_WAIT) && alu_done) begin
        unique case (step)
          STEP_DEN1: begin
            if (den_bad) begin
              line_valid[cls]  <= 1'b0;
              line_slope[cls]  <= '0;
              line_offset[cls] <= '0;
              if (cls) fit_done <= 1'b1;
            end
          end
          STEP_SDIV: line_slope[cls] <= sat_q(numr[SVW-1], alu_res);
          STEP_ODIV: begin
            line_offset[cls] <= sat_q(numr[SVW-1], alu_res);
            line_valid[cls]  <= 1'b1;
            if (cls) fit_done <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Item capture and sequencer datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      x_reg <= x_in;
      y_reg <= y_in;
      lbl   <= point_class;
      pxy   <= x_in * y_in;
      pxx   <= x_in * x_in;
      cls   <= 1'b0;
      pred  <= 1'b0;
      stat  <= STAT_OK;
      unique case (op_in)
        OP_ADD: begin
          if (class_count[point_class] >= CNT_W'(MAX_POINTS)) stat <= STAT_DROP;
        end
        OP_FIT: step <= STEP_DEN0;
        OP_CLASSIFY: begin
          step <= STEP_MX;
          if (!fit_done || (line_valid == 2'b00)) begin
            stat <= STAT_NOFIT;
          end else if (!line_valid[0]) begin
            pred <= 1'b1;
          end
        end
        default: ;
      endcase
    end else if ((state == SEQ_WAIT) && alu_done) begin
      unique case (step)
        STEP_DEN0: begin
          t0   <= prod;
          step <= STEP_DEN1;
        end
        STEP_DEN1: begin
          den <= den_v;
          if (den_bad) begin
            // unfit class: move on to the next one
            cls  <= 1'b1;
            step <= STEP_DEN0;
          end else begin
            step <= STEP_SN0;
          end
        end
        STEP_SN0: begin
          t0   <= prod;
          step <= STEP_SN1;
        end
        STEP_SN1: begin
          numr <= t0 - prod;
          step <= STEP_SDIV;
        end
        STEP_SDIV: step <= STEP_ON0;
        STEP_ON0: begin
          t0   <= prod;
          step <= STEP_ON1;
        end
        STEP_ON1: begin
          numr <= t0 - prod;
          step <= STEP_ODIV;
        end
        STEP_ODIV: begin
          cls  <= 1'b1;
          step <= STEP_DEN0;
        end
        STEP_MX: begin
          rtmp <= num_v;
          step <= STEP_RR;
        end
        STEP_RR: begin
          rr[cls] <= alu_res;
          step    <= STEP_MM;
        end
        STEP_MM: begin
          dd[cls] <= alu_res + (VW'(1) << 32);
          if (cls) begin
            step <= STEP_A;
          end else begin
            cls  <= 1'b1;
            step <= STEP_MX;
          end
        end
        STEP_A: begin
          t0   <= prod;
          step <= STEP_B;
        end
        STEP_B: begin
          // ties go to class one
          pred <= (t0 < prod) ? 1'b0 : 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule
